@@ rtl/core/ray_sphere_intersect_assert.svh @@
// Assertion macros shared by the ray-sphere intersection RTL
`ifndef RAY_SPHERE_INTERSECT_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_ASSERT_SVH

// Same-cycle implication, clocked on clk, quiet while rst_n is low
`define RSI_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rsi assertion failed");

// Next-cycle implication, clocked on clk, quiet while rst_n is low
`define RSI_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rsi assertion failed");

`endif

@@ rtl/core/rsi_pkg.sv @@
// Widths and types shared by the ray-sphere intersection pipeline
package rsi_pkg;

    localparam int IN_W   = 32;
    localparam int FRAC   = 16;
    localparam int M_W    = 33;
    localparam int B_W    = 52;
    localparam int C_W    = 52;
    localparam int ABS_W  = 50;
    localparam int HALF_W = 25;
    localparam int DISC_W = 100;
    localparam int ROOT_W = 50;
    localparam int T_W    = 31;
    localparam int Q_W    = 49;

    // data that rides alongside the square-root chain
    typedef struct packed {
        logic                   live;
        logic signed [B_W-1:0]  b;
        logic signed [IN_W-1:0] ox;
        logic signed [IN_W-1:0] oy;
        logic signed [IN_W-1:0] oz;
        logic signed [IN_W-1:0] dx;
        logic signed [IN_W-1:0] dy;
        logic signed [IN_W-1:0] dz;
    } side_t;

endpackage

@@ rtl/core/ray_sphere_intersect.sv @@
// Pipeline: 5 setup stages, 50 square-root cells and 2 finishing stages.
// Throughput: one beat per cycle; the whole pipeline halts only while the
// output register holds a result and out_stall is high.
// Reset: rst_n clears every valid flag asynchronously; data registers are not reset.
// Top level: fixed-point ray-sphere intersection pipeline
`include "ray_sphere_intersect_assert.svh"

module ray_sphere_intersect #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        sphere_present,
    input  logic signed [31:0]          origin_x,
    input  logic signed [31:0]          origin_y,
    input  logic signed [31:0]          origin_z,
    input  logic signed [31:0]          dir_x,
    input  logic signed [31:0]          dir_y,
    input  logic signed [31:0]          dir_z,
    input  logic signed [31:0]          center_x,
    input  logic signed [31:0]          center_y,
    input  logic signed [31:0]          center_z,
    input  logic signed [31:0]          sphere_radius,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        hit,
    output logic [30:0]                 hit_distance,
    output logic signed [31:0]          hit_x,
    output logic signed [31:0]          hit_y,
    output logic signed [31:0]          hit_z
);
    import rsi_pkg::*;

    localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int SH = 32 - CW;
    localparam logic signed [B_W:0] T_MAX = (B_W+1)'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [Q_W-1:0] Q_HI = Q_W'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [Q_W-1:0] Q_LO = -Q_HI - Q_W'(1);

    function automatic logic signed [IN_W-1:0] sext(input logic [IN_W-1:0] v);
        logic signed [IN_W-1:0] u;
        u = $signed(v << SH);
        return u >>> SH;
    endfunction

    logic en;
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    // stage 1: m = o - k
    logic signed [IN_W-1:0] in_o [3];
    logic signed [IN_W-1:0] in_d [3];
    logic signed [IN_W-1:0] in_k [3];
    logic signed [IN_W-1:0] in_r;

    always_comb
    begin
        in_o[0] = sext(origin_x);
        in_o[1] = sext(origin_y);
        in_o[2] = sext(origin_z);
        in_d[0] = sext(dir_x);
        in_d[1] = sext(dir_y);
        in_d[2] = sext(dir_z);
        in_k[0] = sext(center_x);
        in_k[1] = sext(center_y);
        in_k[2] = sext(center_z);
        in_r    = sext(sphere_radius);
    end

    logic                   s1_valid_reg;
    logic                   s1_live_reg;
    logic signed [M_W-1:0]  s1_m_reg [3];
    logic signed [IN_W-1:0] s1_o_reg [3];
    logic signed [IN_W-1:0] s1_d_reg [3];
    logic signed [IN_W-1:0] s1_r_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_live_reg <= sphere_present && (in_r > 0);
            s1_r_reg    <= in_r;
            for (int i = 0; i < 3; i++)
            begin
                s1_m_reg[i] <= M_W'(in_o[i]) - M_W'(in_k[i]);
                s1_o_reg[i] <= in_o[i];
                s1_d_reg[i] <= in_d[i];
            end
        end
    end

    // stage 2: floored products
    logic signed [M_W+IN_W-1:0] p_md [3];
    logic signed [2*M_W-1:0]    p_mm [3];
    logic signed [2*IN_W-1:0]   p_rr;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_md[i] = s1_m_reg[i] * s1_d_reg[i];
            p_mm[i] = s1_m_reg[i] * s1_m_reg[i];
        end
        p_rr = s1_r_reg * s1_r_reg;
    end

    logic                   s2_valid_reg;
    logic                   s2_live_reg;
    logic signed [B_W-1:0]  s2_md_reg [3];
    logic signed [C_W-1:0]  s2_mm_reg [3];
    logic signed [C_W-1:0]  s2_rr_reg;
    logic signed [IN_W-1:0] s2_o_reg [3];
    logic signed [IN_W-1:0] s2_d_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_live_reg <= s1_live_reg;
            s2_rr_reg   <= C_W'(p_rr >>> FRAC);
            for (int i = 0; i < 3; i++)
            begin
                s2_md_reg[i] <= B_W'(p_md[i] >>> FRAC);
                s2_mm_reg[i] <= C_W'(p_mm[i] >>> FRAC);
                s2_o_reg[i]  <= s1_o_reg[i];
                s2_d_reg[i]  <= s1_d_reg[i];
            end
        end
    end

    // stage 3: b and c
    logic                   s3_valid_reg;
    logic                   s3_live_reg;
    logic signed [B_W-1:0]  s3_b_reg;
    logic signed [C_W-1:0]  s3_c_reg;
    logic signed [IN_W-1:0] s3_o_reg [3];
    logic signed [IN_W-1:0] s3_d_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_live_reg <= s2_live_reg;
            s3_b_reg    <= s2_md_reg[0] + s2_md_reg[1] + s2_md_reg[2];
            s3_c_reg    <= s2_mm_reg[0] + s2_mm_reg[1] + s2_mm_reg[2] - s2_rr_reg;
            for (int i = 0; i < 3; i++)
            begin
                s3_o_reg[i] <= s2_o_reg[i];
                s3_d_reg[i] <= s2_d_reg[i];
            end
        end
    end

    // stage 4: reject rays moving away, split |b| for squaring
    logic [B_W-1:0]    b_mag;
    logic [ABS_W-1:0]  b_abs;
    logic [HALF_W-1:0] b_hi;
    logic [HALF_W-1:0] b_lo;

    always_comb
    begin
        b_mag = s3_b_reg[B_W-1] ? B_W'(-s3_b_reg) : B_W'(s3_b_reg);
        b_abs = b_mag[ABS_W-1:0];
        b_hi  = b_abs[ABS_W-1:HALF_W];
        b_lo  = b_abs[HALF_W-1:0];
    end

    logic                   s4_valid_reg;
    logic                   s4_live_reg;
    logic [2*HALF_W-1:0]    s4_hh_reg;
    logic [2*HALF_W-1:0]    s4_hl_reg;
    logic [2*HALF_W-1:0]    s4_ll_reg;
    logic signed [B_W-1:0]  s4_b_reg;
    logic signed [C_W-1:0]  s4_c_reg;
    logic signed [IN_W-1:0] s4_o_reg [3];
    logic signed [IN_W-1:0] s4_d_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_live_reg <= s3_live_reg && !((s3_c_reg > 0) && (s3_b_reg > 0));
            s4_hh_reg   <= b_hi * b_hi;
            s4_hl_reg   <= b_hi * b_lo;
            s4_ll_reg   <= b_lo * b_lo;
            s4_b_reg    <= s3_b_reg;
            s4_c_reg    <= s3_c_reg;
            for (int i = 0; i < 3; i++)
            begin
                s4_o_reg[i] <= s3_o_reg[i];
                s4_d_reg[i] <= s3_d_reg[i];
            end
        end
    end

    // stage 5: b squared
    logic                   s5_valid_reg;
    logic                   s5_live_reg;
    logic [DISC_W-1:0]      s5_bsq_reg;
    logic signed [B_W-1:0]  s5_b_reg;
    logic signed [C_W-1:0]  s5_c_reg;
    logic signed [IN_W-1:0] s5_o_reg [3];
    logic signed [IN_W-1:0] s5_d_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_live_reg <= s4_live_reg;
            s5_bsq_reg  <= (DISC_W'(s4_hh_reg) << (2 * HALF_W))
                         + (DISC_W'(s4_hl_reg) << (HALF_W + 1))
                         + DISC_W'(s4_ll_reg);
            s5_b_reg    <= s4_b_reg;
            s5_c_reg    <= s4_c_reg;
            for (int i = 0; i < 3; i++)
            begin
                s5_o_reg[i] <= s4_o_reg[i];
                s5_d_reg[i] <= s4_d_reg[i];
            end
        end
    end

    // discriminant in Q32.32, negative means a miss
    logic signed [DISC_W:0] disc;
    side_t                  side0;

    always_comb
    begin
        disc        = $signed({1'b0, s5_bsq_reg})
                    - ((DISC_W+1)'(s5_c_reg) <<< FRAC);
        side0.live  = s5_live_reg && !disc[DISC_W];
        side0.b     = s5_b_reg;
        side0.ox    = s5_o_reg[0];
        side0.oy    = s5_o_reg[1];
        side0.oz    = s5_o_reg[2];
        side0.dx    = s5_d_reg[0];
        side0.dy    = s5_d_reg[1];
        side0.dz    = s5_d_reg[2];
    end

    // square-root chain, one result bit per cell
    logic              ch_valid [ROOT_W+1];
    logic [DISC_W-1:0] ch_x     [ROOT_W+1];
    logic [DISC_W-1:0] ch_res   [ROOT_W+1];
    side_t             ch_side  [ROOT_W+1];

    assign ch_valid[0] = s5_valid_reg;
    assign ch_x[0]     = disc[DISC_W] ? '0 : disc[DISC_W-1:0];
    assign ch_res[0]   = '0;
    assign ch_side[0]  = side0;

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_cell
        rsi_sqrt_cell #(
            .ONE_POS (2 * (ROOT_W - 1 - j))
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .prev_valid (ch_valid[j]),
            .prev_x     (ch_x[j]),
            .prev_res   (ch_res[j]),
            .prev_side  (ch_side[j]),
            .valid      (ch_valid[j+1]),
            .x          (ch_x[j+1]),
            .res        (ch_res[j+1]),
            .side       (ch_side[j+1])
        );
    end

    // entry distance t = -b - s, clamped
    side_t              tail;
    logic signed [B_W:0] t_raw;
    logic [T_W-1:0]      t_clamp;

    always_comb
    begin
        tail  = ch_side[ROOT_W];
        t_raw = -(B_W+1)'(tail.b)
              - $signed({3'b000, ch_res[ROOT_W][ROOT_W-1:0]});
        if (t_raw < 0)
            t_clamp = '0;
        else if (t_raw > T_MAX)
            t_clamp = T_W'(T_MAX);
        else
            t_clamp = T_W'(t_raw);
    end

    logic                   t_valid_reg;
    logic                   t_live_reg;
    logic [T_W-1:0]         t_reg;
    logic signed [IN_W-1:0] t_o_reg [3];
    logic signed [IN_W-1:0] t_d_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_live_reg <= tail.live;
            t_reg      <= t_clamp;
            t_o_reg[0] <= tail.ox;
            t_o_reg[1] <= tail.oy;
            t_o_reg[2] <= tail.oz;
            t_d_reg[0] <= tail.dx;
            t_d_reg[1] <= tail.dy;
            t_d_reg[2] <= tail.dz;
        end
    end

    // hit point q = o + floor(t*d), saturated
    logic signed [2*IN_W-1:0] p_td  [3];
    logic signed [Q_W-1:0]    q_sum [3];
    logic signed [IN_W-1:0]   q_sat [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_td[i]  = $signed({1'b0, t_reg}) * t_d_reg[i];
            q_sum[i] = Q_W'(t_o_reg[i]) + Q_W'(p_td[i] >>> FRAC);
            if (q_sum[i] > Q_HI)
                q_sat[i] = IN_W'(Q_HI);
            else if (q_sum[i] < Q_LO)
                q_sat[i] = IN_W'(Q_LO);
            else
                q_sat[i] = IN_W'(q_sum[i]);
        end
    end

    logic                   out_valid_reg;
    logic                   hit_reg;
    logic [T_W-1:0]         dist_reg;
    logic signed [IN_W-1:0] q_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= t_live_reg;
            dist_reg <= t_live_reg ? t_reg : '0;
            for (int i = 0; i < 3; i++)
            begin
                q_reg[i] <= t_live_reg ? q_sat[i] : '0;
            end
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            t_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            t_valid_reg   <= ch_valid[ROOT_W];
            out_valid_reg <= t_valid_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign hit_distance = dist_reg;
    assign hit_x        = q_reg[0];
    assign hit_y        = q_reg[1];
    assign hit_z        = q_reg[2];

    `RSI_ASSERT_IMP(a_miss_zero, out_valid && !hit, hit_distance == '0 && hit_x == '0 && hit_y == '0 && hit_z == '0)
    `RSI_ASSERT_IMP(a_freeze_cause, in_stall, out_valid && out_stall)
    `RSI_ASSERT_NXT(a_drain, en && t_valid_reg, out_valid)

endmodule

@@ rtl/core/rsi_sqrt_cell.sv @@
// One digit step of the pipelined integer square root
module rsi_sqrt_cell #(
    parameter int ONE_POS = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          prev_valid,
    input  logic [rsi_pkg::DISC_W-1:0]    prev_x,
    input  logic [rsi_pkg::DISC_W-1:0]    prev_res,
    input  rsi_pkg::side_t                prev_side,
    output logic                          valid,
    output logic [rsi_pkg::DISC_W-1:0]    x,
    output logic [rsi_pkg::DISC_W-1:0]    res,
    output rsi_pkg::side_t                side
);
    import rsi_pkg::*;

    localparam logic [DISC_W-1:0] ONE = DISC_W'(1) << ONE_POS;

    logic                valid_reg;
    logic [DISC_W-1:0]   x_reg;
    logic [DISC_W-1:0]   x_next;
    logic [DISC_W-1:0]   res_reg;
    logic [DISC_W-1:0]   res_next;
    side_t               side_reg;
    logic [DISC_W-1:0]   trial;
    logic                take;

    always_comb
    begin
        trial = prev_res + ONE;
        take  = (prev_x >= trial);
        if (take)
        begin
            x_next   = prev_x - trial;
            res_next = (prev_res >> 1) + ONE;
        end
        else
        begin
            x_next   = prev_x;
            res_next = prev_res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            res_reg  <= res_next;
            side_reg <= prev_side;
        end
    end

    assign valid = valid_reg;
    assign x     = x_reg;
    assign res   = res_reg;
    assign side  = side_reg;

endmodule
